// File: src/mne_pkg.sv
// Shared types for the envelope nesting unit.
package mne_pkg;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SORT_INIT,
      ST_BLK_INIT,
      ST_M_RD,
      ST_M_CMP,
      ST_LIS_INIT,
      ST_L_RD,
      ST_L_KEY,
      ST_B_CHK,
      ST_B_CMP,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load;
      logic sort_init;
      logic blk_init;
      logic m_read;
      logic m_cmp;
      logic lis_init;
      logic l_read;
      logic l_key;
      logic b_read;
      logic b_cmp;
      logic b_place;
      logic clear;
   } cmd_type;

   typedef struct packed {
      logic n_le1;
      logic blk_end;
      logic blk_last;
      logic pass_last;
      logic search_done;
      logic lis_last;
   } status_type;

   localparam int DEPTH_BITS = 11;

endpackage

// File: src/mne_if.sv
// Item channel interfaces for envelopes in and nesting depths out.
interface mne_req_if #(parameter int VALUE_BITS = 16);
   logic                  valid;
   logic                  ready;
   logic [VALUE_BITS-1:0] env_width;
   logic [VALUE_BITS-1:0] env_height;
   logic                  last_item;
   modport source (output valid, env_width, env_height, last_item, input ready);
   modport sink (input valid, env_width, env_height, last_item, output ready);
endinterface

interface mne_rsp_if;
   logic        valid;
   logic        ready;
   logic [10:0] nest_depth;
   logic        overflowed;
   modport source (output valid, nest_depth, overflowed, input ready);
   modport sink (input valid, nest_depth, overflowed, output ready);
endinterface

// File: src/mne_ctrl.sv
// Sequencer for loading, merge sorting and the longest run search.
module mne_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_last,
   input  logic                rsp_ready,
   input  mne_pkg::status_type status,
   output logic                req_ready,
   output logic                rsp_valid,
   output mne_pkg::cmd_type    cmd
);
   import mne_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_last) state_in = ST_SORT_INIT;
         end
         ST_SORT_INIT: begin
            state_in = status.n_le1 ? ST_LIS_INIT : ST_BLK_INIT;
         end
         ST_BLK_INIT: state_in = ST_M_RD;
         ST_M_RD: state_in = ST_M_CMP;
         ST_M_CMP: begin
            if (!status.blk_end) state_in = ST_M_RD;
            else if (status.blk_last && status.pass_last) state_in = ST_LIS_INIT;
            else state_in = ST_BLK_INIT;
         end
         ST_LIS_INIT: state_in = ST_L_RD;
         ST_L_RD: state_in = ST_L_KEY;
         ST_L_KEY: state_in = ST_B_CHK;
         ST_B_CHK: begin
            if (!status.search_done) state_in = ST_B_CMP;
            else state_in = status.lis_last ? ST_DONE : ST_L_RD;
         end
         ST_B_CMP: state_in = ST_B_CHK;
         ST_DONE: begin
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_SORT_INIT: cmd.sort_init = 1'b1;
         ST_BLK_INIT:  cmd.blk_init = 1'b1;
         ST_M_RD:      cmd.m_read = 1'b1;
         ST_M_CMP:     cmd.m_cmp = 1'b1;
         ST_LIS_INIT:  cmd.lis_init = 1'b1;
         ST_L_RD:      cmd.l_read = 1'b1;
         ST_L_KEY:     cmd.l_key = 1'b1;
         ST_B_CHK: begin
            cmd.b_read  = !status.search_done;
            cmd.b_place = status.search_done;
         end
         ST_B_CMP: cmd.b_cmp = 1'b1;
         ST_DONE: begin
            rsp_valid = 1'b1;
            cmd.clear = rsp_ready;
         end
         default: cmd = '0;
      endcase
   end

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("Result offered while items are taken.");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_B_CMP) |=> (state_ff == ST_B_CHK))
      else $error("Search compare did not return to the check step.");
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("Result withdrawn before it was taken.");
endmodule

// File: src/mne_dpath.sv
// Envelope stores, merge sort counters and the tail table search.
module mne_dpath #(
   parameter int MAX_ITEMS  = 1024,
   parameter int VALUE_BITS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  mne_pkg::cmd_type        cmd,
   input  logic [VALUE_BITS-1:0]   env_width,
   input  logic [VALUE_BITS-1:0]   env_height,
   output mne_pkg::status_type     status,
   output logic [10:0]             nest_depth,
   output logic                    overflowed
);
   import mne_pkg::*;

   localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
   localparam int CW = $clog2(MAX_ITEMS + 1);
   localparam int WW = CW + 2;
   localparam int KW = 2 * VALUE_BITS;
   localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_ITEMS);

   logic [KW-1:0]         mem0 [MAX_ITEMS];
   logic [KW-1:0]         mem1 [MAX_ITEMS];
   logic [VALUE_BITS-1:0] tail_mem [MAX_ITEMS];

   logic [CW-1:0]         count_ff, i_ff, len_ff, blo_ff, bhi_ff;
   logic                  ovf_ff, sel_ff;
   logic [WW-1:0]         span_ff, lo_ff, mid_ff, hi_ff, a_ff, b_ff, k_ff;
   logic [KW-1:0]         rd0a_ff, rd0b_ff, rd1a_ff, rd1b_ff;
   logic [VALUE_BITS-1:0] h_ff, tail_rd_ff;

   logic [WW-1:0]         n_w, lo_span, lo_2span, mid_c, hi_c;
   logic [KW-1:0]         rda, rdb, wr_key;
   logic                  take_b;
   logic [AW-1:0]         addr_a, addr_b;
   logic [CW:0]           bsum;
   logic [CW-1:0]         bmid;
   logic [CW+10:0]        depth_ext;

   assign n_w      = WW'(count_ff);
   assign lo_span  = lo_ff + span_ff;
   assign lo_2span = lo_ff + (span_ff << 1);
   assign mid_c    = (lo_span > n_w) ? n_w : lo_span;
   assign hi_c     = (lo_2span > n_w) ? n_w : lo_2span;
   assign rda      = sel_ff ? rd1a_ff : rd0a_ff;
   assign rdb      = sel_ff ? rd1b_ff : rd0b_ff;
   assign take_b   = (b_ff < hi_ff) && ((a_ff >= mid_ff) || (rdb < rda));
   assign wr_key   = take_b ? rdb : rda;
   assign addr_a   = cmd.l_read ? i_ff[AW-1:0] : a_ff[AW-1:0];
   assign addr_b   = b_ff[AW-1:0];
   assign bsum     = {1'b0, blo_ff} + {1'b0, bhi_ff};
   assign bmid     = bsum[CW:1];

   assign status.n_le1       = (count_ff <= CW'(1));
   assign status.blk_end     = (k_ff + WW'(1) == hi_ff);
   assign status.blk_last    = (lo_2span >= n_w);
   assign status.pass_last   = ((span_ff << 1) >= n_w);
   assign status.search_done = (blo_ff >= bhi_ff);
   assign status.lis_last    = (i_ff + CW'(1) == count_ff);

   assign depth_ext  = {11'b0, len_ff};
   assign nest_depth = depth_ext[10:0];
   assign overflowed = ovf_ff;

   always_ff @(posedge clock) begin
      if (cmd.load && (count_ff < MAX_COUNT)) begin
         mem0[count_ff[AW-1:0]] <= {env_width, ~env_height};
      end else if (cmd.m_cmp && sel_ff) begin
         mem0[k_ff[AW-1:0]] <= wr_key;
      end
      if (cmd.m_cmp && !sel_ff) begin
         mem1[k_ff[AW-1:0]] <= wr_key;
      end
      rd0a_ff <= mem0[addr_a];
      rd0b_ff <= mem0[addr_b];
      rd1a_ff <= mem1[addr_a];
      rd1b_ff <= mem1[addr_b];
      if (cmd.b_place) begin
         tail_mem[blo_ff[AW-1:0]] <= h_ff;
      end
      tail_rd_ff <= tail_mem[bmid[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ovf_ff   <= 1'b0;
         len_ff   <= '0;
         sel_ff   <= 1'b0;
      end else begin
         if (cmd.load) begin
            if (count_ff < MAX_COUNT) count_ff <= count_ff + CW'(1);
            else ovf_ff <= 1'b1;
         end
         if (cmd.clear) begin
            count_ff <= '0;
            ovf_ff   <= 1'b0;
         end
         if (cmd.sort_init) sel_ff <= 1'b0;
         if (cmd.m_cmp && status.blk_end && status.blk_last) sel_ff <= !sel_ff;
         if (cmd.lis_init) len_ff <= '0;
         if (cmd.b_place && (blo_ff == len_ff)) len_ff <= len_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.sort_init) begin
         span_ff <= WW'(1);
         lo_ff   <= '0;
      end
      if (cmd.blk_init) begin
         mid_ff <= mid_c;
         hi_ff  <= hi_c;
         a_ff   <= lo_ff;
         b_ff   <= mid_c;
         k_ff   <= lo_ff;
      end
      if (cmd.m_cmp) begin
         if (take_b) b_ff <= b_ff + WW'(1);
         else a_ff <= a_ff + WW'(1);
         k_ff <= k_ff + WW'(1);
         if (status.blk_end) begin
            if (status.blk_last) begin
               span_ff <= span_ff << 1;
               lo_ff   <= '0;
            end else begin
               lo_ff <= lo_2span;
            end
         end
      end
      if (cmd.lis_init) i_ff <= '0;
      if (cmd.l_key) begin
         h_ff   <= ~rda[VALUE_BITS-1:0];
         blo_ff <= '0;
         bhi_ff <= len_ff;
      end
      if (cmd.b_cmp) begin
         if (tail_rd_ff < h_ff) blo_ff <= bmid + CW'(1);
         else bhi_ff <= bmid;
      end
      if (cmd.b_place) i_ff <= i_ff + CW'(1);
   end

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= MAX_COUNT)
      else $error("Item count beyond store depth.");
   assert property (@(posedge clock) disable iff (reset)
      cmd.b_cmp |-> (blo_ff < bhi_ff))
      else $error("Search step taken on an empty range.");
   assert property (@(posedge clock) disable iff (reset)
      cmd.b_place |-> (blo_ff <= len_ff) && (len_ff <= i_ff))
      else $error("Tail table placement out of range.");
endmodule

// File: src/max_nested_envelopes_unit.sv
// Top level of the envelope nesting unit.
// Items load one per cycle while the unit is idle; a set of n items is then merge sorted
// and searched with the tail table before its nesting depth is offered.
// Throughput: one set at a time, bounded by the sort passes and the tail table port.
// Reset: synchronous, clears the sequencer, item count and overflow flag; stores are not cleared.
module max_nested_envelopes_unit #(
   parameter int MAX_ITEMS  = 1024,
   parameter int VALUE_BITS = 16
) (
   input  logic      clock,
   input  logic      reset,
   mne_req_if.sink   req_chan,
   mne_rsp_if.source rsp_chan
);
   import mne_pkg::*;

   cmd_type    cmd;
   status_type status;

   mne_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_last  (req_chan.last_item),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .cmd       (cmd)
   );

   mne_dpath #(
      .MAX_ITEMS  (MAX_ITEMS),
      .VALUE_BITS (VALUE_BITS)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .env_width  (req_chan.env_width),
      .env_height (req_chan.env_height),
      .status     (status),
      .nest_depth (rsp_chan.nest_depth),
      .overflowed (rsp_chan.overflowed)
   );
endmodule
